[hdl/icrm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icrm_pkg
// Types, address map and sizes shared by the interrupt controller register map.
// ----------------------------------------------------------------------------
package icrm_pkg;

  // Bank depths in words
  localparam int CHANNEL_MAP_WORDS = 256;
  localparam int HOST_MAP_WORDS    = 64;
  localparam int STATUS_WORDS      = 32;
  localparam int PRIORITY_WORDS    = 256;
  localparam int HOST_ENABLE_WORDS = 8;
  localparam int SCALAR_COUNT      = 10;

  // Both state memories share one depth so a single pass clears them
  localparam int MEM_DEPTH = 512;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  // Status memory layout (word offsets)
  localparam logic [MEM_AW-1:0] RAW_BASE  = 9'h000;
  localparam logic [MEM_AW-1:0] EN_BASE   = 9'h020;
  localparam logic [MEM_AW-1:0] ESET_BASE = 9'h040;
  localparam logic [MEM_AW-1:0] ECLR_BASE = 9'h060;
  localparam logic [MEM_AW-1:0] HEN_BASE  = 9'h080;
  localparam logic [MEM_AW-1:0] PRIO_BASE = 9'h100;

  // Map memory layout (word offsets)
  localparam logic [MEM_AW-1:0] CHAN_BASE = 9'h000;
  localparam logic [MEM_AW-1:0] HOST_BASE = 9'h100;

  // Scalar register reset values and slots
  localparam logic [31:0] REVISION_RESET = 32'h4e82_0100;
  localparam logic [31:0] CONTROL_RESET  = 32'h0000_0010;
  localparam logic [3:0]  SC_REVISION    = 4'd0;
  localparam logic [3:0]  SC_CONTROL     = 4'd1;
  localparam logic [3:0]  SC_REG0        = 4'd2;
  localparam logic [3:0]  SC_REG1        = 4'd3;
  localparam logic [3:0]  SC_REG2        = 4'd4;
  localparam logic [3:0]  SC_REG3        = 4'd5;
  localparam logic [3:0]  SC_REG4        = 4'd6;
  localparam logic [3:0]  SC_REG5        = 4'd7;
  localparam logic [3:0]  SC_REG6        = 4'd8;
  localparam logic [3:0]  SC_REG7        = 4'd9;

  // Operation codes
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_EVENT = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Where a bus address lands
  typedef enum logic [1:0] {
    TGT_BAD    = 2'd0,
    TGT_STATUS = 2'd1,
    TGT_MAP    = 2'd2,
    TGT_SCALAR = 2'd3
  } target_t;

  // Item held while it is worked on
  typedef struct packed {
    op_t               op;
    target_t           tgt;
    logic              w1c;
    logic [MEM_AW-1:0] a_idx;
    logic [MEM_AW-1:0] b_idx;
    logic [3:0]        sc_idx;
    logic [31:0]       wdata;
    logic [4:0]        bit_sel;
    logic [1:0]        byte_sel;
    logic              stat_ok;
    logic              chan_ok;
    logic [7:0]        core;
  } item_t;

  // One result word
  typedef struct packed {
    logic [31:0] read_data;
    logic        bad_address;
    logic        host_valid;
    logic [7:0]  host_line;
    logic [7:0]  core_out;
  } result_t;

endpackage

[hdl/interrupt_controller_register_map_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_controller_register_map_unit
// Register banks of an interrupt controller with system-to-channel-to-host
// event mapping, held in two synchronous memories with separate read and write ports.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)                      | tuser
//  in_     | in  | address, write_data, system_event, target_core | operation
//  out_    | out | read_data, host_line, core_out                 | bad_address, host_valid
//
//  A bus read or write moves from accept through the lookup state into the
//  output register; an event also passes the host state, as the two dependent
//  reads of the map memory (channel, then host) lie in sequence. One word is
//  worked on at a time, so the next word cannot be accepted before the last
//  has left the lookup states; the next is taken once the result sits in the
//  output register, and that register may wait on out_tready.
//  After reset a clearing pass over all 512 words zeroes both memories, with
//  in_tready low. A stalled output holds the engine in its send state.
// ----------------------------------------------------------------------------
module interrupt_controller_register_map_unit
  import icrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // address[12:0], write_data, system_event, target_core, pad
  input  logic [1:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // read_data[31:0], host_line, core_out
  output logic [1:0]  out_tuser   // bad_address, host_valid
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LOOK  = 5'b00100,
    ST_HOST  = 5'b01000,
    ST_SEND  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [MEM_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  item_t             item_r, item_nxt;
  result_t           res_r, res_nxt;
  logic [1:0]        host_sel_r;
  logic              host_ok_r;
  logic [31:0]       scal_r [SCALAR_COUNT];
  logic              out_tvalid_r;
  logic [47:0]       out_tdata_r;
  logic [1:0]        out_tuser_r;

  // Memories
  logic [31:0]       mem_a [MEM_DEPTH];
  logic [31:0]       mem_b [MEM_DEPTH];
  logic [31:0]       mem_a_q, mem_b_q;
  logic              a_we, b_we, a_re, b_re;
  logic [MEM_AW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
  logic [31:0]       a_wdata, b_wdata;

  logic              in_acc, slot_free, deliver;
  logic [12:0]       addr;
  logic [12:0]       prio_off;
  logic [9:0]        sys;
  logic [7:0]        chan;
  item_t             dec;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign slot_free = !out_tvalid_r || out_tready;
  assign addr      = in_tdata[12:0];
  assign sys       = in_tdata[54:45];
  assign prio_off  = addr - 13'h900;
  assign chan      = mem_b_q[{item_r.byte_sel, 3'b000} +: 8];

  // Decode of an incoming word
  always_comb begin
    dec          = '0;
    dec.op       = op_t'(in_tuser);
    dec.wdata    = in_tdata[44:13];
    dec.core     = in_tdata[62:55];
    dec.bit_sel  = sys[4:0];
    dec.byte_sel = sys[1:0];
    dec.tgt      = TGT_BAD;
    if (dec.op == OP_EVENT) begin
      dec.a_idx   = EN_BASE + MEM_AW'(sys[9:5]);
      dec.b_idx   = CHAN_BASE + MEM_AW'(sys[9:2]);
      dec.stat_ok = int'(sys[9:5]) < STATUS_WORDS;
      dec.chan_ok = int'(sys[9:2]) < CHANNEL_MAP_WORDS;
    end else if (addr inside {[13'h200:13'h27f]}) begin
      dec.a_idx = RAW_BASE + MEM_AW'(addr[6:2]);
      if (int'(addr[6:2]) < STATUS_WORDS) dec.tgt = TGT_STATUS;
    end else if (addr inside {[13'h280:13'h2ff]}) begin
      dec.a_idx = EN_BASE + MEM_AW'(addr[6:2]);
      dec.w1c   = 1'b1;
      if (int'(addr[6:2]) < STATUS_WORDS) dec.tgt = TGT_STATUS;
    end else if (addr inside {[13'h300:13'h37f]}) begin
      dec.a_idx = ESET_BASE + MEM_AW'(addr[6:2]);
      if (int'(addr[6:2]) < STATUS_WORDS) dec.tgt = TGT_STATUS;
    end else if (addr inside {[13'h380:13'h3ff]}) begin
      dec.a_idx = ECLR_BASE + MEM_AW'(addr[6:2]);
      if (int'(addr[6:2]) < STATUS_WORDS) dec.tgt = TGT_STATUS;
    end else if (addr inside {[13'h400:13'h7ff]}) begin
      dec.b_idx = CHAN_BASE + MEM_AW'(addr[9:2]);
      if (int'(addr[9:2]) < CHANNEL_MAP_WORDS) dec.tgt = TGT_MAP;
    end else if (addr inside {[13'h800:13'h8ff]}) begin
      dec.b_idx = HOST_BASE + MEM_AW'(addr[7:2]);
      if (int'(addr[7:2]) < HOST_MAP_WORDS) dec.tgt = TGT_MAP;
    end else if (addr inside {[13'h900:13'hcff]}) begin
      dec.a_idx = PRIO_BASE + MEM_AW'(prio_off[9:2]);
      if (int'(prio_off[9:2]) < PRIORITY_WORDS) dec.tgt = TGT_STATUS;
    end else if (addr inside {[13'h1500:13'h151f]}) begin
      dec.a_idx = HEN_BASE + MEM_AW'(addr[4:2]);
      if (int'(addr[4:2]) < HOST_ENABLE_WORDS) dec.tgt = TGT_STATUS;
    end else begin
      dec.tgt = TGT_SCALAR;
      case (addr)
        13'h0000: dec.sc_idx = SC_REVISION;
        13'h0004: dec.sc_idx = SC_CONTROL;
        13'h0010: dec.sc_idx = SC_REG0;
        13'h0020: dec.sc_idx = SC_REG1;
        13'h0024: dec.sc_idx = SC_REG2;
        13'h0028: dec.sc_idx = SC_REG3;
        13'h002c: dec.sc_idx = SC_REG4;
        13'h0034: dec.sc_idx = SC_REG5;
        13'h0038: dec.sc_idx = SC_REG6;
        13'h0080: dec.sc_idx = SC_REG7;
        default:  dec.tgt    = TGT_BAD;
      endcase
    end
  end

  // Memory port control
  always_comb begin
    a_re    = in_acc;
    a_raddr = dec.a_idx;
    b_re    = in_acc || (state_r == ST_LOOK);
    b_raddr = (state_r == ST_LOOK) ? (HOST_BASE + MEM_AW'(chan[7:2])) : dec.b_idx;
    a_we    = 1'b0;
    a_waddr = item_r.a_idx;
    a_wdata = item_r.w1c ? (mem_a_q & ~item_r.wdata) : item_r.wdata;
    b_we    = 1'b0;
    b_waddr = item_r.b_idx;
    b_wdata = item_r.wdata;
    if (state_r == ST_CLEAR) begin
      a_we    = 1'b1;
      a_waddr = clr_cnt_r;
      a_wdata = '0;
      b_we    = 1'b1;
      b_waddr = clr_cnt_r;
      b_wdata = '0;
    end else if (state_r == ST_LOOK) begin
      if (item_r.op == OP_WRITE) begin
        a_we = (item_r.tgt == TGT_STATUS);
        b_we = (item_r.tgt == TGT_MAP);
      end else if (item_r.op == OP_EVENT) begin
        a_we    = item_r.stat_ok;
        a_wdata = mem_a_q | (32'd1 << item_r.bit_sel);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) mem_a[a_waddr] <= a_wdata;
    if (a_re) mem_a_q <= mem_a[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) mem_b[b_waddr] <= b_wdata;
    if (b_re) mem_b_q <= mem_b[b_raddr];
  end

  // Result of the current step
  always_comb begin
    res_nxt = '0;
    if (state_r == ST_HOST) begin
      if (host_ok_r) begin
        res_nxt.host_valid = 1'b1;
        res_nxt.host_line  = mem_b_q[{host_sel_r, 3'b000} +: 8];
        res_nxt.core_out   = item_r.core;
      end
    end else if ((item_r.op == OP_READ) || (item_r.op == OP_WRITE)) begin
      res_nxt.bad_address = (item_r.tgt == TGT_BAD);
      if (item_r.op == OP_READ) begin
        case (item_r.tgt)
          TGT_STATUS: res_nxt.read_data = mem_a_q;
          TGT_MAP:    res_nxt.read_data = mem_b_q;
          TGT_SCALAR: res_nxt.read_data = scal_r[item_r.sc_idx];
          default:    res_nxt.read_data = '0;
        endcase
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    item_nxt    = item_r;
    deliver     = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == MEM_AW'(MEM_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          item_nxt  = dec;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if ((item_r.op == OP_EVENT) && item_r.chan_ok) begin
          state_nxt = ST_HOST;
        end else begin
          deliver   = slot_free;
          state_nxt = slot_free ? ST_IDLE : ST_SEND;
        end
      end
      ST_HOST: begin
        deliver   = slot_free;
        state_nxt = slot_free ? ST_IDLE : ST_SEND;
      end
      ST_SEND: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Held item, host byte select and parked result
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    if (state_r == ST_LOOK) begin
      host_sel_r <= chan[1:0];
      host_ok_r  <= int'(chan[7:2]) < HOST_MAP_WORDS;
    end
    if ((state_r == ST_LOOK) || (state_r == ST_HOST)) res_r <= res_nxt;
  end

  // Scalar registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SCALAR_COUNT; i++) begin
        if (i == int'(SC_REVISION)) scal_r[i] <= REVISION_RESET;
        else if (i == int'(SC_CONTROL)) scal_r[i] <= CONTROL_RESET;
        else scal_r[i] <= '0;
      end
    end else if ((state_r == ST_LOOK) && (item_r.op == OP_WRITE) &&
                 (item_r.tgt == TGT_SCALAR)) begin
      scal_r[item_r.sc_idx] <= item_r.wdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (deliver || ((state_r == ST_SEND) && slot_free)) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      out_tdata_r <= {res_nxt.core_out, res_nxt.host_line, res_nxt.read_data};
      out_tuser_r <= {res_nxt.host_valid, res_nxt.bad_address};
    end else if ((state_r == ST_SEND) && slot_free) begin
      out_tdata_r <= {res_r.core_out, res_r.host_line, res_r.read_data};
      out_tuser_r <= {res_r.host_valid, res_r.bad_address};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  // An event walks through both lookup states
  a_event_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == OP_EVENT))
      |=> (state_r == ST_LOOK) ##1 (state_r == ST_HOST))
    else $error("event did not reach host lookup");

  // Bus access and host interrupt never reported together
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("bad_address and host_valid both set");

  // Memories are not written while waiting for a word
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!a_we && !b_we))
    else $error("memory write while idle");

  // A taken word always moves to the lookup state
  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_LOOK))
    else $error("accepted word not processed");
`endif

endmodule

[tb/tb_interrupt_controller_register_map_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interrupt_controller_register_map_unit
// Self-checking bench for the interrupt controller register map. A scoreboard
// class keeps its own copy of every bank, predicts one result word per input
// word (bus read, bus write, system event) and compares each output word
// field by field in order. Stimulus is a directed pass over the address map
// edges followed by random traffic biased toward map programming and events,
// with random idling on both channels, one long output hold-off and one
// drain pause.
// ----------------------------------------------------------------------------
module tb_interrupt_controller_register_map_unit;
  import icrm_pkg::*;

  // Byte offsets of the register banks
  localparam logic [12:0] A_RAW    = 13'h0200;
  localparam logic [12:0] A_EN     = 13'h0280;
  localparam logic [12:0] A_ESET   = 13'h0300;
  localparam logic [12:0] A_ECLR   = 13'h0380;
  localparam logic [12:0] A_CHAN   = 13'h0400;
  localparam logic [12:0] A_HOST   = 13'h0800;
  localparam logic [12:0] A_PRIO   = 13'h0900;
  localparam logic [12:0] A_HEN    = 13'h1500;
  localparam logic [12:0] A_REV    = 13'h0000;
  localparam logic [12:0] A_CTRL   = 13'h0004;

  localparam int RANDOM_WORDS = 1400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;

  // Register bank a byte offset falls in
  typedef enum int {
    BK_NONE, BK_RAW, BK_EN, BK_ESET, BK_ECLR, BK_CHAN, BK_HOST, BK_PRIO, BK_HEN, BK_SCALAR
  } bank_t;

  // --------------------------------------------------------------------------
  // Register map predictor and ordered result checker
  // --------------------------------------------------------------------------
  class irq_map_scoreboard;
    logic [31:0] raw_st  [STATUS_WORDS];
    logic [31:0] en_st   [STATUS_WORDS];
    logic [31:0] en_set  [STATUS_WORDS];
    logic [31:0] en_clr  [STATUS_WORDS];
    logic [31:0] chan_map[CHANNEL_MAP_WORDS];
    logic [31:0] host_map[HOST_MAP_WORDS];
    logic [31:0] prio    [PRIORITY_WORDS];
    logic [31:0] host_en [HOST_ENABLE_WORDS];
    logic [31:0] scalars [SCALAR_COUNT];
    result_t     expected_q[$];
    int          mismatches;

    function new();
      foreach (raw_st[i]) begin
        raw_st[i] = '0; en_st[i] = '0; en_set[i] = '0; en_clr[i] = '0;
      end
      foreach (chan_map[i]) chan_map[i] = '0;
      foreach (host_map[i]) host_map[i] = '0;
      foreach (prio[i]) prio[i] = '0;
      foreach (host_en[i]) host_en[i] = '0;
      foreach (scalars[i]) scalars[i] = '0;
      scalars[SC_REVISION] = REVISION_RESET;
      scalars[SC_CONTROL]  = CONTROL_RESET;
      mismatches = 0;
    endfunction

    // Bank and word index of a byte offset; low two bits ignored inside banks
    function void locate(input logic [12:0] a, output bank_t bk, output int idx);
      bk  = BK_NONE;
      idx = 0;
      if (a >= A_RAW && a < A_EN) begin bk = BK_RAW; idx = (a - A_RAW) >> 2; end
      else if (a >= A_EN && a < A_ESET) begin bk = BK_EN; idx = (a - A_EN) >> 2; end
      else if (a >= A_ESET && a < A_ECLR) begin bk = BK_ESET; idx = (a - A_ESET) >> 2; end
      else if (a >= A_ECLR && a < A_CHAN) begin bk = BK_ECLR; idx = (a - A_ECLR) >> 2; end
      else if (a >= A_CHAN && a < A_HOST) begin bk = BK_CHAN; idx = (a - A_CHAN) >> 2; end
      else if (a >= A_HOST && a < A_PRIO) begin bk = BK_HOST; idx = (a - A_HOST) >> 2; end
      else if (a >= A_PRIO && a <= 13'h0cff) begin bk = BK_PRIO; idx = (a - A_PRIO) >> 2; end
      else if (a >= A_HEN && a <= 13'h151f) begin bk = BK_HEN; idx = (a - A_HEN) >> 2; end
      else begin
        bk = BK_SCALAR;
        case (a)
          A_REV:    idx = SC_REVISION;
          A_CTRL:   idx = SC_CONTROL;
          13'h0010: idx = SC_REG0;
          13'h0020: idx = SC_REG1;
          13'h0024: idx = SC_REG2;
          13'h0028: idx = SC_REG3;
          13'h002c: idx = SC_REG4;
          13'h0034: idx = SC_REG5;
          13'h0038: idx = SC_REG6;
          13'h0080: idx = SC_REG7;
          default:  bk = BK_NONE;
        endcase
      end
    endfunction

    // Accepted input word: update state and queue the expected result
    function void note_word(op_t op, logic [12:0] addr, logic [31:0] data,
                            logic [9:0] sys, logic [7:0] core);
      result_t want;
      bank_t   bk;
      int      idx;
      logic [7:0] ch;
      want = '0;
      case (op)
        OP_READ, OP_WRITE: begin
          locate(addr, bk, idx);
          if (bk == BK_NONE) begin
            want.bad_address = 1'b1;
          end else if (op == OP_READ) begin
            case (bk)
              BK_RAW:  want.read_data = raw_st[idx];
              BK_EN:   want.read_data = en_st[idx];
              BK_ESET: want.read_data = en_set[idx];
              BK_ECLR: want.read_data = en_clr[idx];
              BK_CHAN: want.read_data = chan_map[idx];
              BK_HOST: want.read_data = host_map[idx];
              BK_PRIO: want.read_data = prio[idx];
              BK_HEN:  want.read_data = host_en[idx];
              default: want.read_data = scalars[idx];
            endcase
          end else begin
            case (bk)
              BK_RAW:  raw_st[idx] = data;
              BK_EN:   en_st[idx] = en_st[idx] & ~data;  // write one to clear
              BK_ESET: en_set[idx] = data;
              BK_ECLR: en_clr[idx] = data;
              BK_CHAN: chan_map[idx] = data;
              BK_HOST: host_map[idx] = data;
              BK_PRIO: prio[idx] = data;
              BK_HEN:  host_en[idx] = data;
              default: scalars[idx] = data;
            endcase
          end
        end
        OP_EVENT: begin
          // status bit, then channel byte, then host byte of that channel
          en_st[sys >> 5][sys[4:0]] = 1'b1;
          ch = chan_map[sys >> 2][sys[1:0]*8 +: 8];
          want.host_line  = host_map[ch >> 2][ch[1:0]*8 +: 8];
          want.host_valid = 1'b1;
          want.core_out   = core;
        end
        default: ;  // unknown operation: all zero, nothing changes
      endcase
      expected_q.push_back(want);
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] mismatch %s: expected 0x%08h, got 0x%08h", $realtime, what, want, got);
    endfunction

    // Output word: compare with the oldest expectation
    function void check_word(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected word", '0, got.read_data);
        return;
      end
      want = expected_q.pop_front();
      if (got.read_data !== want.read_data) report("read_data", want.read_data, got.read_data);
      if (got.bad_address !== want.bad_address)
        report("bad_address", want.bad_address, got.bad_address);
      if (got.host_valid !== want.host_valid)
        report("host_valid", want.host_valid, got.host_valid);
      if (got.host_line !== want.host_line) report("host_line", want.host_line, got.host_line);
      if (got.core_out !== want.core_out) report("core_out", want.core_out, got.core_out);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // address[12:0], write_data, system_event, target_core, pad
  logic [1:0]  in_tuser;   // operation
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // read_data[31:0], host_line, core_out
  logic [1:0]  out_tuser;  // bad_address, host_valid

  irq_map_scoreboard sb = new();
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int cycles   = 0;

  interrupt_controller_register_map_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one input word and wait until it is taken
  task automatic send_word(op_t op, logic [12:0] addr, logic [31:0] data,
                           logic [9:0] sys, logic [7:0] core);
    if (idle_on && $urandom_range(0, 99) < 6) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, core, sys, data, addr};
    do @(posedge clk); while (!in_tready);
    sb.note_word(op, addr, data, sys, core);
  endtask

  task automatic bus_write(logic [12:0] addr, logic [31:0] data);
    send_word(OP_WRITE, addr, data, 10'($urandom), 8'($urandom));
  endtask

  task automatic bus_read(logic [12:0] addr);
    send_word(OP_READ, addr, $urandom, 10'($urandom), 8'($urandom));
  endtask

  // Random byte offset, weighted toward mapped banks and their edges
  function automatic logic [12:0] pick_addr(bit maps_only);
    logic [12:0] edges[8] = '{13'h0008, 13'h0100, 13'h01ff, 13'h0084,
                              13'h0d00, 13'h14fc, 13'h1520, 13'h1fff};
    logic [12:0] scal[10] = '{13'h0000, 13'h0004, 13'h0010, 13'h0020, 13'h0024,
                              13'h0028, 13'h002c, 13'h0034, 13'h0038, 13'h0080};
    case (maps_only ? $urandom_range(2, 3) : $urandom_range(0, 8))
      0: return 13'($urandom);
      1: return 13'($urandom_range(A_RAW, 13'h03ff));
      2: return 13'($urandom_range(A_CHAN, 13'h07ff));
      3: return 13'($urandom_range(A_HOST, 13'h08ff));
      4: return 13'($urandom_range(A_PRIO, 13'h0cff));
      5: return 13'($urandom_range(A_HEN, 13'h151f));
      6: return scal[$urandom_range(0, 9)];
      7: return edges[$urandom_range(0, 7)];
      default: return 13'($urandom_range(A_EN, 13'h02ff));
    endcase
  endfunction

  // Receiver: checks output words, idles at random, one long hold-off
  initial begin
    int      hold_left;
    result_t got;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got.read_data   = out_tdata[31:0];
        got.host_line   = out_tdata[39:32];
        got.core_out    = out_tdata[47:40];
        got.bad_address = out_tuser[0];
        got.host_valid  = out_tuser[1];
        sb.check_word(got);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(idle_on && $urandom_range(0, 99) < 6);
      end
    end
  end

  // Sender: reset, directed words, random words, drain and verdict
  initial begin
    int   pick;
    op_t  op;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_READ;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values and scalar slots
    bus_read(A_REV);
    bus_read(A_CTRL);
    bus_write(13'h0080, 32'hffff_ffff);
    bus_read(13'h0080);
    bus_write(A_CTRL, 32'h0000_0000);
    // Unmapped offsets: misaligned scalar, gaps, top of space
    bus_read(13'h0003);
    bus_write(13'h1fff, 32'hffff_ffff);
    bus_read(13'h0d00);
    bus_write(13'h1520, 32'h1234_5678);
    // Highest system event maps through last channel byte to last host byte
    bus_write(13'h07ff, 32'hff3f_0201);
    bus_write(13'h08fc, 32'ha500_0000);
    send_word(OP_EVENT, 13'h1fff, 32'hffff_ffff, 10'd1023, 8'd255);
    send_word(OP_EVENT, 13'h0000, 32'h0000_0000, 10'd0, 8'd0);
    // Enabled status picks up event bits and clears on write of ones
    bus_read(A_EN);
    bus_read(13'h02fc);
    bus_write(13'h02ff, 32'h8000_0000);
    bus_read(13'h02fc);
    // Bank extremes
    bus_write(A_RAW, 32'hffff_ffff);
    bus_read(13'h027c);
    bus_write(13'h151f, 32'hdead_beef);
    bus_read(13'h151c);
    bus_write(13'h0cff, 32'h0f0f_0f0f);
    bus_read(A_PRIO);
    bus_write(A_ESET, 32'haaaa_aaaa);
    bus_write(13'h03fc, 32'h5555_5555);
    // Unknown operation with every field high
    send_word(OP_NONE, 13'h1fff, 32'hffff_ffff, 10'h3ff, 8'hff);

    // Random traffic: mostly map programming and events
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      idle_on = !(n >= 300 && n < 600);
      if (n == 450) hold_req = 1'b1;
      if (n == 1000) begin
        in_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 38) op = OP_EVENT;
      else if (pick < 68) op = OP_WRITE;
      else if (pick < 96) op = OP_READ;
      else op = OP_NONE;
      send_word(op, pick_addr(op == OP_WRITE && $urandom_range(0, 1)),
                $urandom, 10'($urandom), 8'($urandom));
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/icrm_pkg.sv
hdl/interrupt_controller_register_map_unit.sv
tb/tb_interrupt_controller_register_map_unit.sv
